/* rtl/spfrs_pkg.sv */
// Package for the smallest-prime-factor rank sieve.
// Holds field widths, reset constants, the controller state type and the
// command and status structs shared by the controller and the datapath.
`default_nettype none

package spfrs_pkg;

   localparam int NUM_W       = 11;
   localparam int LABEL_W     = 10;
   localparam int DEF_MAX_N   = 1024;

   localparam logic [NUM_W-1:0]   LIMIT_RESET = 11'd1024;
   localparam logic [LABEL_W-1:0] RANK_RESET  = 10'd1;
   localparam logic [LABEL_W-1:0] RANK_MAX    = 10'd1023;

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_LOOKUP = 7'b0000100,
      ST_CHECK  = 7'b0001000,
      ST_MREAD  = 7'b0010000,
      ST_MWRITE = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   typedef struct packed {
      logic clr_en;     // write zero at the clear pointer and advance it
      logic capture;    // take the incoming number
      logic rd_j;       // read address is the multiple pointer, else the number
      logic hit;        // result label is the stored label
      logic miss;       // result label is zero (number out of range)
      logic mark_num;   // label the new prime, start the multiple pointer
      logic mark_j;     // label the multiple if unlabeled, step the pointer
      logic rsp_load;   // move the result into the output register
   } cmd_type;

   typedef struct packed {
      logic clr_last;   // clear pointer is at the last entry
      logic in_range;   // captured number is between 2 and the limit
      logic stored_zero;// registered read data is zero
      logic j_over;     // multiple pointer is beyond the limit
   } status_type;

endpackage

`default_nettype wire

/* rtl/spfrs_ctrl.sv */
// Controller state machine for the rank sieve.
// Uses spfrs_pkg; drives datapath commands from handshakes and datapath status.
`default_nettype none

module spfrs_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire spfrs_pkg::status_type sts,
   output spfrs_pkg::cmd_type        cmd
);

   spfrs_pkg::state_type state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;

   assign req_ready = (state_ff == spfrs_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         spfrs_pkg::ST_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (sts.clr_last) begin
               state_in = spfrs_pkg::ST_IDLE;
            end
         end
         spfrs_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = spfrs_pkg::ST_LOOKUP;
            end
         end
         spfrs_pkg::ST_LOOKUP: begin
            // The read of the number's entry is issued here.
            if (sts.in_range) begin
               state_in = spfrs_pkg::ST_CHECK;
            end else begin
               cmd.miss = 1'b1;
               state_in = spfrs_pkg::ST_DONE;
            end
         end
         spfrs_pkg::ST_CHECK: begin
            if (sts.stored_zero) begin
               cmd.mark_num = 1'b1;
               state_in     = spfrs_pkg::ST_MREAD;
            end else begin
               cmd.hit  = 1'b1;
               state_in = spfrs_pkg::ST_DONE;
            end
         end
         spfrs_pkg::ST_MREAD: begin
            cmd.rd_j = 1'b1;
            if (sts.j_over) begin
               state_in = spfrs_pkg::ST_DONE;
            end else begin
               state_in = spfrs_pkg::ST_MWRITE;
            end
         end
         spfrs_pkg::ST_MWRITE: begin
            cmd.mark_j = 1'b1;
            state_in   = spfrs_pkg::ST_MREAD;
         end
         spfrs_pkg::ST_DONE: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = spfrs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spfrs_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spfrs_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/spfrs_dpath.sv */
// Datapath for the rank sieve: label memory, limit register, rank counter,
// multiple pointer and output register. Uses spfrs_pkg; driven by spfrs_ctrl.
`default_nettype none

module spfrs_dpath #(
   parameter int MAX_N = spfrs_pkg::DEF_MAX_N
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [spfrs_pkg::NUM_W-1:0]   csr_wr_data,
   input  wire logic [spfrs_pkg::NUM_W-1:0]   req_number,
   output logic      [spfrs_pkg::LABEL_W-1:0] rsp_label,
   output logic                               rsp_last,
   input  wire spfrs_pkg::cmd_type            cmd,
   output spfrs_pkg::status_type              sts
);

   localparam int AW = $clog2(MAX_N + 1);
   // Multiples run up to limit plus one step, so the pointer needs 12 bits.
   localparam int JW = (AW > spfrs_pkg::NUM_W + 1) ? AW : spfrs_pkg::NUM_W + 1;
   localparam int unsigned MaxN = MAX_N;

   logic [spfrs_pkg::LABEL_W-1:0] mem [0:MAX_N];

   logic [spfrs_pkg::NUM_W-1:0]   limit_ff;
   logic [spfrs_pkg::NUM_W-1:0]   lim;
   logic [spfrs_pkg::NUM_W-1:0]   num_ff;
   logic                          last_ff;
   logic [JW-1:0]                 num_ext;
   logic [JW-1:0]                 lim_ext;
   logic [JW-1:0]                 j_ff, j_in;
   logic [AW-1:0]                 clr_ff;
   logic [spfrs_pkg::LABEL_W-1:0] rank_ff, rank_in;
   logic [spfrs_pkg::LABEL_W-1:0] res_ff, res_in;
   logic [spfrs_pkg::LABEL_W-1:0] rd_data_ff;
   logic [spfrs_pkg::LABEL_W-1:0] out_label_ff;
   logic                          out_last_ff;
   logic [AW-1:0]                 rd_addr;
   logic [AW-1:0]                 wr_addr;
   logic [spfrs_pkg::LABEL_W-1:0] wr_data;
   logic                          wr_en;

   always_comb begin
      if (32'(limit_ff) > MaxN) begin
         lim = spfrs_pkg::NUM_W'(MAX_N);
      end else begin
         lim = limit_ff;
      end
   end

   assign num_ext = JW'(num_ff);
   assign lim_ext = JW'(lim);

   assign sts.clr_last    = (clr_ff == AW'(MAX_N));
   assign sts.in_range    = (num_ff >= spfrs_pkg::NUM_W'(2)) && (num_ff <= lim);
   assign sts.stored_zero = (rd_data_ff == '0);
   assign sts.j_over      = (j_ff > lim_ext);

   assign rd_addr = cmd.rd_j ? j_ff[AW-1:0] : num_ext[AW-1:0];

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_data = '0;
      if (cmd.clr_en) begin
         wr_en = 1'b1;
      end else if (cmd.mark_num) begin
         wr_en   = 1'b1;
         wr_addr = num_ext[AW-1:0];
         wr_data = rank_ff;
      end else if (cmd.mark_j) begin
         // The pointer's entry was read in the previous cycle.
         wr_en   = sts.stored_zero;
         wr_addr = j_ff[AW-1:0];
         wr_data = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      j_in    = j_ff;
      rank_in = rank_ff;
      res_in  = res_ff;
      if (cmd.mark_num) begin
         j_in   = num_ext + num_ext;
         res_in = rank_ff;
         if (rank_ff < spfrs_pkg::RANK_MAX) begin
            rank_in = rank_ff + spfrs_pkg::LABEL_W'(1);
         end
      end else if (cmd.mark_j) begin
         j_in = j_ff + num_ext;
      end else if (cmd.hit) begin
         res_in = rd_data_ff;
      end else if (cmd.miss) begin
         res_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= spfrs_pkg::LIMIT_RESET;
         rank_ff  <= spfrs_pkg::RANK_RESET;
         clr_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         rank_ff <= rank_in;
         if (cmd.clr_en) begin
            clr_ff <= clr_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      j_ff   <= j_in;
      res_ff <= res_in;
      if (cmd.capture) begin
         num_ff <= req_number;
      end
      if (cmd.rsp_load) begin
         out_label_ff <= res_ff;
         out_last_ff  <= last_ff;
      end
   end

   // The last flag is registered from the captured number, against the current limit.
   always_ff @(posedge clock) begin
      last_ff <= (num_ff == lim);
   end

   assign rsp_label = out_label_ff;
   assign rsp_last  = out_last_ff;

endmodule

`default_nettype wire

/* rtl/smallest_prime_factor_rank_sieve.sv */
// Top level of the smallest-prime-factor rank sieve.
// Uses spfrs_pkg; instantiates spfrs_ctrl and spfrs_dpath.
//
//   Channel   Ports                                 Direction  Handshake
//   req       req_valid, req_ready, req_number      in         valid/ready
//   rsp       rsp_valid, rsp_ready, rsp_label/last  out        valid/ready
//   csr       csr_wr_en, csr_wr_data (limit)        in         write enable
//
// After reset a clearing pass writes zero to all MAX_N+1 label entries, one per
// cycle, and req_ready stays low until that pass ends.
// An out-of-range number goes from lookup straight to done; a number already
// labeled passes through lookup, check and done.
// A new prime p then walks its multiples up to the limit: each multiple costs one read
// and one conditional write on the label memory, plus one last read.
// The output register lets the next item be accepted while a result waits.
`default_nettype none

module smallest_prime_factor_rank_sieve #(
   parameter int MAX_N = spfrs_pkg::DEF_MAX_N
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [spfrs_pkg::NUM_W-1:0]   csr_wr_data,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [spfrs_pkg::NUM_W-1:0]   req_number,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [spfrs_pkg::LABEL_W-1:0] rsp_label,
   output logic                               rsp_last
);

   spfrs_pkg::cmd_type    cmd;
   spfrs_pkg::status_type sts;

   spfrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   spfrs_dpath #(
      .MAX_N (MAX_N)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_number  (req_number),
      .rsp_label   (rsp_label),
      .rsp_last    (rsp_last),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

`default_nettype wire

/* tb/tb_smallest_prime_factor_rank_sieve.sv */
// Self-checking testbench for the smallest-prime-factor rank sieve.
// Depends on spfrs_pkg and smallest_prime_factor_rank_sieve; a built-in sieve predictor
// works out every label and last flag, and a checker compares each returned item.
module tb_smallest_prime_factor_rank_sieve;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_N       = spfrs_pkg::DEF_MAX_N;
   localparam int IDLE_HEAVY  = 76;
   localparam int IDLE_LIGHT  = 11;
   localparam int PACE_SPAN   = 97;
   localparam int NUM_TOP     = (1 << spfrs_pkg::NUM_W) - 1;

   typedef enum int {
      PACE_NONE,
      PACE_SENDER,
      PACE_RECEIVER,
      PACE_BOTH
   } pace_type;

   typedef struct packed {
      logic [spfrs_pkg::NUM_W-1:0]   number;
      logic [spfrs_pkg::LABEL_W-1:0] label;
      logic                          last;
   } spf_result_type;

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          csr_wr_en   = 1'b0;
   logic [spfrs_pkg::NUM_W-1:0]   csr_wr_data = '0;
   logic                          req_valid   = 1'b0;
   logic [spfrs_pkg::NUM_W-1:0]   req_number  = '0;
   logic                          rsp_ready   = 1'b0;
   logic                          req_ready;
   logic                          rsp_valid;
   logic [spfrs_pkg::LABEL_W-1:0] rsp_label;
   logic                          rsp_last;

   // Predictor state: label memory, rank counter and the limit register.
   logic [spfrs_pkg::LABEL_W-1:0] label_mem [0:MAX_N] = '{default: '0};
   logic [spfrs_pkg::LABEL_W-1:0] rank_next = spfrs_pkg::RANK_RESET;
   logic [spfrs_pkg::NUM_W-1:0]   limit_reg = spfrs_pkg::LIMIT_RESET;

   spf_result_type pending_labels[$];
   spf_result_type head_label;

   int items_sent     = 0;
   int labels_checked = 0;
   int mismatch_count = 0;
   int limit_writes   = 0;
   int send_idle_pct  = 0;
   int stall_pct      = 0;

   smallest_prime_factor_rank_sieve #(
      .MAX_N(MAX_N)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_number (req_number),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_label  (rsp_label),
      .rsp_last   (rsp_last)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // The run must finish well inside this bound.
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic int unsigned eff_limit();
      return (limit_reg > MAX_N) ? MAX_N : limit_reg;
   endfunction

   // Labels one number the way the sieve does and updates the predictor state.
   function automatic spf_result_type sieve_label(input logic [spfrs_pkg::NUM_W-1:0] num);
      int unsigned eff;
      int unsigned j;
      spf_result_type res;
      eff = eff_limit();
      res.number = num;
      res.label  = '0;
      res.last   = (num == eff);
      if (num >= 2 && num <= eff) begin
         if (label_mem[num] != '0) begin
            res.label = label_mem[num];
         end else begin
            // An unlabeled number is a new prime, even when it arrives out of order.
            res.label = rank_next;
            label_mem[num] = rank_next;
            for (j = 2 * num; j <= eff; j += num) begin
               if (label_mem[j] == '0) begin
                  label_mem[j] = rank_next;
               end
            end
            if (rank_next < spfrs_pkg::RANK_MAX) begin
               rank_next = rank_next + 1'b1;
            end
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic send_number(input logic [spfrs_pkg::NUM_W-1:0] num);
      pace_type pace;
      pace = pace_type'((items_sent / PACE_SPAN) % 4);
      case (pace)
         PACE_NONE: begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         PACE_SENDER: begin
            send_idle_pct = IDLE_HEAVY;
            stall_pct     = 0;
         end
         PACE_RECEIVER: begin
            send_idle_pct = 0;
            stall_pct     = IDLE_HEAVY;
         end
         default: begin
            send_idle_pct = IDLE_LIGHT;
            stall_pct     = IDLE_LIGHT;
         end
      endcase
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_number <= num;
      do @(posedge clock); while (!req_ready);
      pending_labels = {pending_labels, sieve_label(num)};
      items_sent++;
   endtask

   // Drops valid and waits until every expected item is back and the block is idle.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_labels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [spfrs_pkg::NUM_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_reg = value;
      limit_writes++;
   endtask

   // Out-of-range numbers, limits at and beyond both ends, and a short ascending run.
   task automatic test_edge_items();
      int unsigned num;
      send_number(spfrs_pkg::NUM_W'(0));
      send_number(spfrs_pkg::NUM_W'(1));
      send_number(spfrs_pkg::NUM_W'(NUM_TOP));
      send_number(spfrs_pkg::NUM_W'(MAX_N + 1));
      settle_block();
      write_limit(spfrs_pkg::NUM_W'(0));
      send_number(spfrs_pkg::NUM_W'(0));
      send_number(spfrs_pkg::NUM_W'(2));
      settle_block();
      write_limit(spfrs_pkg::NUM_W'(1));
      send_number(spfrs_pkg::NUM_W'(1));
      send_number(spfrs_pkg::NUM_W'(NUM_TOP));
      settle_block();
      write_limit(spfrs_pkg::NUM_W'(2));
      send_number(spfrs_pkg::NUM_W'(2));
      send_number(spfrs_pkg::NUM_W'(2));
      send_number(spfrs_pkg::NUM_W'(3));
      settle_block();
      write_limit(spfrs_pkg::NUM_W'(12));
      for (num = 3; num <= 12; num++) begin
         send_number(spfrs_pkg::NUM_W'(num));
      end
      send_number(spfrs_pkg::NUM_W'(12));
      settle_block();
      // A limit above the store size clamps; the top number arrives out of order.
      write_limit(spfrs_pkg::NUM_W'(NUM_TOP));
      send_number(spfrs_pkg::NUM_W'(MAX_N));
      send_number(spfrs_pkg::NUM_W'(MAX_N + 1));
      settle_block();
   endtask

   // Ascending runs under a growing limit, with repeats, swapped pairs and stray numbers.
   task automatic test_sieve_runs();
      int unsigned prev_limit;
      int unsigned run_limit;
      int unsigned num;
      int unsigned pick;
      prev_limit = 12;
      while (items_sent < 975 && prev_limit < 720) begin
         run_limit = prev_limit + $urandom_range(10, 140);
         write_limit(spfrs_pkg::NUM_W'(run_limit));
         num = (prev_limit < 64) ? 2 : prev_limit - $urandom_range(0, 24);
         while (num <= run_limit) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
               send_number(spfrs_pkg::NUM_W'(num));
            end else if (pick < 10 && num < run_limit) begin
               send_number(spfrs_pkg::NUM_W'(num + 1));
               send_number(spfrs_pkg::NUM_W'(num));
               num += 2;
            end else if (pick < 16) begin
               send_number(spfrs_pkg::NUM_W'($urandom_range(0, NUM_TOP)));
            end else begin
               send_number(spfrs_pkg::NUM_W'(num));
               num++;
            end
         end
         send_number(spfrs_pkg::NUM_W'(run_limit + 1));
         settle_block();
         prev_limit = run_limit;
      end
   endtask

   // Random numbers in any order under large limits, weighted toward the limit itself.
   task automatic test_scattered_numbers();
      int unsigned eff;
      int unsigned pick;
      int unsigned num;
      int s;
      for (s = 0; s < 3; s++) begin
         if (s == 0) begin
            write_limit(spfrs_pkg::NUM_W'($urandom_range(720, MAX_N - 1)));
         end else if (s == 1) begin
            write_limit(spfrs_pkg::NUM_W'(MAX_N));
         end else begin
            write_limit(spfrs_pkg::NUM_W'(NUM_TOP));
         end
         eff = eff_limit();
         repeat (150) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
               num = $urandom_range(2, eff);
            end else if (pick < 75) begin
               num = eff;
            end else if (pick < 85) begin
               num = ($urandom_range(1) == 0) ? eff - 1 : eff + 1;
            end else begin
               num = $urandom_range(0, NUM_TOP);
            end
            send_number(spfrs_pkg::NUM_W'(num));
         end
         settle_block();
      end
   endtask

   // Descending from the top, where every unlabeled number takes a rank of its own.
   task automatic test_descending_tail();
      int unsigned num;
      write_limit(spfrs_pkg::NUM_W'(MAX_N));
      for (num = MAX_N; num >= 880; num--) begin
         send_number(spfrs_pkg::NUM_W'(num));
      end
      settle_block();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         labels_checked++;
         if (pending_labels.size() == 0) begin
            report_mismatch($sformatf("unexpected item: label %0d last %0b",
                                      rsp_label, rsp_last));
         end else begin
            head_label = pending_labels.pop_front();
            if (rsp_label !== head_label.label) begin
               report_mismatch($sformatf("number %0d: label %0d, expected %0d",
                                         head_label.number, rsp_label, head_label.label));
            end
            if (rsp_last !== head_label.last) begin
               report_mismatch($sformatf("number %0d: last %0b, expected %0b",
                                         head_label.number, rsp_last, head_label.last));
            end
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_edge_items();
      test_sieve_runs();
      test_scattered_numbers();
      test_descending_tail();
      // Give any stray item time to show up.
      repeat (20) @(posedge clock);
      $display("Sent %0d numbers under %0d limit writes; %0d labels compared.",
               items_sent, limit_writes, labels_checked);
      $display("Next free rank at the end: %0d; mismatches: %0d.",
               rank_next, mismatch_count);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
